// ===== rtl/xsfb_pkg.sv =====
package xsfb_pkg;

    localparam int LINE_BITS  = 64;
    localparam int ROW_PIXELS = 8;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_DRAW  = 2'd1,
        KIND_READ  = 2'd2
    } xsfb_kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } xsfb_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] start_x;
        logic [7:0] start_y;
        logic [3:0] row_index;
        logic [7:0] row_bits;
        logic       last_row;
        logic [4:0] line_select;
    } xsfb_in_t;

    typedef struct packed {
        logic                 collision;
        logic [LINE_BITS-1:0] line_pixels;
        logic                 sprite_done;
    } xsfb_out_t;

endpackage

// ===== rtl/xor_sprite_framebuffer_top.sv =====
// Result: the command and the line read are registered at the start transfer, the modify state
//   (ST_EXEC) works out the result, and result_reg registers it; result_valid is shown for one cycle only.
// Flow: busy is high in the modify state, so a new item is taken only once the read-modify-write of
//   one 64-bit line in the frame memory, whose read is registered, is through; a clear screen passes the same states.
// Reset: rst_n is asynchronous and active low; it clears the control state, the collision
//   flag and the per-line valid bits, so every line reads as all pixels off at once.
// The receiver cannot stall: each result is taken in the cycle it is shown.
module xor_sprite_framebuffer_top #(
    parameter int WIDTH  = 64,
    parameter int HEIGHT = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  xsfb_pkg::xsfb_in_t  cmd,
    output xsfb_pkg::xsfb_out_t result,
    output logic              result_valid
);
    import xsfb_pkg::*;

    // Column, line and address widths follow the screen size.
    localparam int XW = $clog2(WIDTH);
    localparam int YW = $clog2(HEIGHT);
    localparam int AW = $clog2(HEIGHT);
    localparam int LW = $clog2(HEIGHT + 16);
    localparam logic [LW-1:0]        HEIGHT_L = LW'(HEIGHT);
    // Ones on the columns that exist; everything right of WIDTH is clipped.
    localparam logic [LINE_BITS-1:0] COL_MASK = ~({LINE_BITS{1'b1}} >> WIDTH);

    // Frame store: one line per entry, column 0 at the top bit.
    logic [LINE_BITS-1:0] frame_mem [HEIGHT];
    logic [LINE_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    // A line whose valid bit is low has not been drawn since reset or the last clear.
    logic [HEIGHT-1:0] line_valid_reg, line_valid_next;

    xsfb_state_t state_reg, state_next;

    // Command held across the read-modify-write.
    logic [1:0]    kind_reg;
    logic [XW-1:0] x_reg;
    logic [AW-1:0] addr_reg;
    logic          in_range_reg;
    logic [7:0]    row_bits_reg;
    logic          last_row_reg;
    logic          first_row_reg;

    logic collision_reg, collision_next;
    xsfb_out_t result_reg, result_next;
    logic      result_valid_reg, result_valid_next;

    // Modulo tables for the start coordinates, worked out at elaboration.
    logic [XW-1:0] x_mod_tab [256];
    logic [YW-1:0] y_mod_tab [256];

    for (genvar i = 0; i < 256; i++) begin : g_mod_tab
        assign x_mod_tab[i] = XW'(i % WIDTH);
        assign y_mod_tab[i] = YW'(i % HEIGHT);
    end

    // Address decode at the start transfer.
    logic          accept;
    logic [LW-1:0] line_sum;
    logic [LW-1:0] sel_ext;
    logic          line_ok;
    logic          sel_ok;
    logic [AW-1:0] rd_addr;
    logic          rd_in_range;

    assign accept   = start && !busy;
    assign line_sum = LW'(y_mod_tab[cmd.start_y]) + LW'(cmd.row_index);
    assign sel_ext  = LW'(cmd.line_select);
    assign line_ok  = line_sum < HEIGHT_L;
    assign sel_ok   = sel_ext < HEIGHT_L;

    always_comb
    begin
        rd_addr     = '0;
        rd_in_range = 1'b0;
        if (cmd.kind == KIND_DRAW) begin
            rd_in_range = line_ok;
            if (line_ok) begin
                rd_addr = line_sum[AW-1:0];
            end
        end else if (cmd.kind == KIND_READ) begin
            rd_in_range = sel_ok;
            if (sel_ok) begin
                rd_addr = sel_ext[AW-1:0];
            end
        end
    end

    // Modify stage: line as stored, sprite mask and collision test.
    logic [LINE_BITS-1:0] cur_line;
    logic [LINE_BITS-1:0] sprite_mask;
    logic                 hit;
    logic                 mem_wr_en;

    assign cur_line    = rd_valid_reg ? rd_data_reg : '0;
    assign sprite_mask = ((LINE_BITS'(row_bits_reg) << (LINE_BITS - ROW_PIXELS)) >> x_reg)
                         & COL_MASK;
    assign hit         = |(cur_line & sprite_mask);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        busy      = 1'b0;
        mem_wr_en = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_EXEC:
            begin
                busy      = 1'b1;
                mem_wr_en = (kind_reg == KIND_DRAW) && in_range_reg;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Flag, valid bits and result for the item in the modify stage.
    always_comb
    begin
        collision_next    = collision_reg;
        line_valid_next   = line_valid_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        if (state_reg == ST_EXEC) begin
            if (kind_reg == KIND_CLEAR) begin
                line_valid_next = '0;
            end else if (kind_reg == KIND_DRAW) begin
                // Row 0 starts a new sprite: drop the old flag before testing.
                collision_next = (collision_reg && !first_row_reg) || (in_range_reg && hit);
                if (in_range_reg) begin
                    line_valid_next[addr_reg] = 1'b1;
                end
            end
            result_next.collision   = collision_next;
            result_next.line_pixels = (kind_reg == KIND_READ && in_range_reg) ? cur_line : '0;
            result_next.sprite_done = (kind_reg == KIND_DRAW) && last_row_reg;
            result_valid_next       = 1'b1;
        end
    end

    // Frame memory: synchronous read, write back of the modified line.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en) begin
            frame_mem[addr_reg] <= cur_line ^ sprite_mask;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

    // Hold the command for the modify stage.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            kind_reg      <= cmd.kind;
            x_reg         <= x_mod_tab[cmd.start_x];
            addr_reg      <= rd_addr;
            in_range_reg  <= rd_in_range;
            row_bits_reg  <= cmd.row_bits;
            last_row_reg  <= cmd.last_row;
            first_row_reg <= (cmd.row_index == 4'd0);
            rd_valid_reg  <= line_valid_reg[rd_addr];
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            line_valid_reg   <= '0;
            collision_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end else begin
            state_reg        <= state_next;
            line_valid_reg   <= line_valid_next;
            collision_reg    <= collision_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/xsfb_checker.sv =====
module xsfb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input xsfb_pkg::xsfb_out_t result,
    input logic              result_valid
);
    import xsfb_pkg::*;

    // A transfer locks the command port for the modify cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a start transfer");

    // Every transfer yields its result after the modify state and the result register.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 result_valid)
        else $error("result missing two cycles after a start transfer");

    // One result per transfer: the strobe is never held high.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    // Line data and sprite completion never show together.
    a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.sprite_done) |-> (result.line_pixels == '0))
        else $error("line pixels reported on a drawn row");

endmodule

bind xor_sprite_framebuffer_top xsfb_checker u_xsfb_checker (.*);
